FILE: src/rlrd_pkg.sv
// ----------------------------------------------------------------------------
// rlrd_pkg
// Shared constants, codes and controller/datapath interface types for the
// rate limited link with random drop.
// ----------------------------------------------------------------------------
package rlrd_pkg;

  localparam int QDEPTH = 64;
  localparam int AW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int OW     = $clog2(QDEPTH + 1);
  localparam int PW     = OW + 8;

  localparam int CNT_W  = 20;
  localparam int CAP_W  = 7;
  localparam int RND_W  = 7;
  localparam int SEQ_W  = 32;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int CFG_W  = 20;

  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] RATE_RESET    = CNT_W'(100);
  localparam logic [CAP_W-1:0] CAP_RESET     = CAP_W'(64);
  localparam int               PCT_SCALE     = 100;

  localparam logic CFG_RATE_LIMIT = 1'b0;
  localparam logic CFG_QUEUE_CAP  = 1'b1;

  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] ACT_FORWARD  = 2'd0;
  localparam logic [1:0] ACT_QUEUED   = 2'd1;
  localparam logic [1:0] ACT_DROPPED  = 2'd2;
  localparam logic [1:0] ACT_RELEASED = 2'd3;

  typedef struct packed {
    logic capture;
    logic pkt_eval;
    logic tick_clear;
    logic drain_start;
    logic drain_read;
    logic drain_emit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic occ_zero;
    logic out_free;
    logic drain_last;
  } sts_t;

endpackage

FILE: src/rate_limited_link_with_random_drop.sv
// ----------------------------------------------------------------------------
// rate_limited_link_with_random_drop
// Emulated bottleneck link: per-period rate limit, random early drop and a
// queue released on each period tick.
// ----------------------------------------------------------------------------
// A packet transaction is first captured and then, once the output register is
// free, evaluated: the count update and the drop compare (two small multiplies,
// the queue occupancy times the percent scale and the random value plus one times
// the capacity). A tick releases the queue from a single-port memory one entry at
// a time (memory read, then output load), and an empty tick gives no result.
// The next transaction is accepted once the previous one has left the
// sequencer; a result waiting in the output register does not hold off input,
// and an output stall holds the sequencer in its evaluate or output state.
module rate_limited_link_with_random_drop import rlrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [SEQ_W-1:0]  seq_i,
  input  logic [ADDR_W-1:0] src_addr_i,
  input  logic [PORT_W-1:0] src_port_i,
  input  logic [RND_W-1:0]  random_pct_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [PORT_W-1:0] out_port_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  rlrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlrd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .seq_i        (seq_i),
    .src_addr_i   (src_addr_i),
    .src_port_i   (src_port_i),
    .random_pct_i (random_pct_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .out_seq_o    (out_seq_o),
    .out_addr_o   (out_addr_o),
    .out_port_o   (out_port_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

FILE: src/rlrd_ctrl.sv
// ----------------------------------------------------------------------------
// rlrd_ctrl
// Sequencer: captures one transaction, evaluates a packet or drains the
// queue on a tick, one entry at a time.
// ----------------------------------------------------------------------------
module rlrd_ctrl import rlrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DRD  = 2'd2;
  localparam logic [1:0] S_DOUT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.is_tick) begin
          if (sts_i.occ_zero) begin
            cmd_o.tick_clear = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.drain_start = 1'b1;
            state_d           = S_DRD;
          end
        end else if (sts_i.out_free) begin
          cmd_o.pkt_eval = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.drain_read = 1'b1;
        state_d          = S_DOUT;
      end
      S_DOUT: begin
        if (sts_i.out_free) begin
          cmd_o.drain_emit = 1'b1;
          state_d          = sts_i.drain_last ? S_IDLE : S_DRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/rlrd_datapath.sv
// ----------------------------------------------------------------------------
// rlrd_datapath
// Configuration, period count, occupancy, packet queue memory, drop
// decision and output register.
// ----------------------------------------------------------------------------
module rlrd_datapath import rlrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              func_i,
  input  logic [SEQ_W-1:0]  seq_i,
  input  logic [ADDR_W-1:0] src_addr_i,
  input  logic [PORT_W-1:0] src_port_i,
  input  logic [RND_W-1:0]  random_pct_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [PORT_W-1:0] out_port_o,
  output logic              last_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  localparam int EW = SEQ_W + ADDR_W + PORT_W;

  logic [CNT_W-1:0] rate_q;
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OW-1:0]    occ_q;
  logic [AW-1:0]    idx_q;

  logic              func_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [ADDR_W-1:0] addr_q;
  logic [PORT_W-1:0] port_q;
  logic [RND_W-1:0]  rnd_q;

  logic [EW-1:0] mem [QDEPTH];
  logic [EW-1:0] rd_q;

  logic              out_valid_q;
  logic [1:0]        action_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [PORT_W-1:0] out_port_q;
  logic              last_q;

  logic [OW-1:0]    cap_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             forward;
  logic             full;
  logic             drop;
  logic [PW-1:0]    prod_occ;
  logic [PW-1:0]    prod_rnd;
  logic             do_queue;
  logic             out_free;
  logic             drain_last;
  logic             load_out;

  // effective capacity clamped to one..depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = OW'(1);
    end else if (cap_q > CAP_W'(QDEPTH)) begin
      cap_eff = OW'(QDEPTH);
    end else begin
      cap_eff = cap_q[OW-1:0];
    end
  end

  assign cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
  assign forward  = (cnt_inc <= rate_q);
  assign full     = (occ_q >= cap_eff);
  // rnd < floor(occ*100/cap)  <=>  occ*100 >= (rnd+1)*cap
  assign prod_occ = PW'(occ_q) * PW'(PCT_SCALE);
  assign prod_rnd = PW'({1'b0, rnd_q} + 8'd1) * PW'(cap_eff);
  assign drop     = full || (prod_occ >= prod_rnd);
  assign do_queue = cmd_i.pkt_eval && !forward && !drop;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign drain_last = ((OW'(idx_q) + OW'(1)) == occ_q);
  assign load_out   = cmd_i.pkt_eval || cmd_i.drain_emit;

  assign sts_o.is_tick    = (func_q == FUNC_TICK);
  assign sts_o.occ_zero   = (occ_q == '0);
  assign sts_o.out_free   = out_free;
  assign sts_o.drain_last = drain_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RESET;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      occ_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RATE_LIMIT) begin
          rate_q <= cfg_data_i;
        end else begin
          cap_q <= cfg_data_i[CAP_W-1:0];
        end
      end
      if (cmd_i.pkt_eval) begin
        cnt_q <= cnt_inc;
      end
      if (cmd_i.tick_clear) begin
        cnt_q <= '0;
      end
      if (do_queue) begin
        occ_q <= occ_q + OW'(1);
      end
      if (cmd_i.drain_start) begin
        idx_q <= '0;
      end
      if (cmd_i.drain_emit) begin
        if (drain_last) begin
          cnt_q <= CNT_W'(occ_q);
          occ_q <= '0;
        end else begin
          idx_q <= idx_q + AW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      seq_q  <= seq_i;
      addr_q <= src_addr_i;
      port_q <= src_port_i;
      rnd_q  <= random_pct_i;
    end
    if (do_queue) begin
      mem[occ_q[AW-1:0]] <= {seq_q, addr_q, port_q};
    end
    if (cmd_i.drain_read) begin
      rd_q <= mem[idx_q];
    end
    if (cmd_i.pkt_eval) begin
      action_q   <= forward ? ACT_FORWARD : (drop ? ACT_DROPPED : ACT_QUEUED);
      out_seq_q  <= seq_q;
      out_addr_q <= addr_q;
      out_port_q <= port_q;
      last_q     <= 1'b1;
    end
    if (cmd_i.drain_emit) begin
      action_q   <= ACT_RELEASED;
      out_seq_q  <= rd_q[EW-1 -: SEQ_W];
      out_addr_q <= rd_q[PORT_W +: ADDR_W];
      out_port_q <= rd_q[PORT_W-1:0];
      last_q     <= drain_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign out_seq_o   = out_seq_q;
  assign out_addr_o  = out_addr_q;
  assign out_port_o  = out_port_q;
  assign last_o      = last_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(QDEPTH))
    else $error("occupancy beyond queue depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("pending result overwritten");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drain_read |-> (occ_q != '0))
    else $error("drain read with empty queue");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.drain_emit && drain_last) |=> (occ_q == '0) && out_valid_q && last_q)
    else $error("queue not emptied after last release");

endmodule

FILE: test/rate_limited_link_with_random_drop_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_limited_link_with_random_drop_test
// Self-checking bench for the rate limited link: directed cases for the rate
// limit, capacity bounds, queue full and empty ticks, then random traffic
// under several sender idle and receiver stall mixes. A behavioral model of
// the link predicts every result transaction, which is checked in order.
// ----------------------------------------------------------------------------
module rate_limited_link_with_random_drop_test;
  import rlrd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]        action;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              last;
  } link_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_idx_i    = CFG_RATE_LIMIT;
  logic [CFG_W-1:0]  cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              func_i       = 1'b0;
  logic [SEQ_W-1:0]  seq_i        = '0;
  logic [ADDR_W-1:0] src_addr_i   = '0;
  logic [PORT_W-1:0] src_port_i   = '0;
  logic [RND_W-1:0]  random_pct_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [1:0]        action_o;
  logic [SEQ_W-1:0]  out_seq_o;
  logic [ADDR_W-1:0] out_addr_o;
  logic [PORT_W-1:0] out_port_o;
  logic              last_o;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int fail_count         = 0;

  // link model state
  logic [CNT_W-1:0]  model_rate   = RATE_RESET;
  logic [CAP_W-1:0]  model_cap    = CAP_RESET;
  logic [CNT_W-1:0]  period_count = '0;
  int                queue_fill   = 0;
  logic [SEQ_W-1:0]  held_seq  [QDEPTH];
  logic [ADDR_W-1:0] held_addr [QDEPTH];
  logic [PORT_W-1:0] held_port [QDEPTH];

  link_result_t pending_results[$];

  rate_limited_link_with_random_drop dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .seq_i        (seq_i),
    .src_addr_i   (src_addr_i),
    .src_port_i   (src_port_i),
    .random_pct_i (random_pct_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .out_seq_o    (out_seq_o),
    .out_addr_o   (out_addr_o),
    .out_port_o   (out_port_o),
    .last_o       (last_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (receiver_stall_pct != 0) && ($urandom_range(0, 99) < receiver_stall_pct);
  end

  function automatic void note_failure(string what, link_result_t want, link_result_t got);
    if (fail_count < MAX_REPORTS) begin
      $display("%0t %s: expected act=%0d seq=%h addr=%h port=%h last=%b", $time, what,
               want.action, want.seq, want.addr, want.port, want.last);
      $display("%0t %s:   actual act=%0d seq=%h addr=%h port=%h last=%b", $time, what,
               got.action, got.seq, got.addr, got.port, got.last);
    end
    fail_count++;
  endfunction

  // expected results of one accepted transaction
  function automatic void predict_link(logic func, logic [SEQ_W-1:0] s,
                                       logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                                       logic [RND_W-1:0] r);
    int cap;
    int threshold;
    if (func == FUNC_TICK) begin
      for (int i = 0; i < queue_fill; i++) begin
        pending_results.push_back('{ACT_RELEASED, held_seq[i], held_addr[i], held_port[i],
                                    (i == queue_fill - 1)});
      end
      period_count = CNT_W'(queue_fill);
      queue_fill   = 0;
      return;
    end
    if (period_count != CNT_MAX) period_count++;
    if (period_count <= model_rate) begin
      pending_results.push_back('{ACT_FORWARD, s, a, p, 1'b1});
      return;
    end
    cap = int'(model_cap);
    if (cap == 0) cap = 1;
    if (cap > QDEPTH) cap = QDEPTH;
    threshold = queue_fill * PCT_SCALE / cap;
    if (queue_fill >= cap || int'(r) < threshold) begin
      pending_results.push_back('{ACT_DROPPED, s, a, p, 1'b1});
    end else begin
      held_seq[queue_fill]  = s;
      held_addr[queue_fill] = a;
      held_port[queue_fill] = p;
      queue_fill++;
      pending_results.push_back('{ACT_QUEUED, s, a, p, 1'b1});
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    link_result_t got;
    link_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{action_o, out_seq_o, out_addr_o, out_port_o, last_o};
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_failure("result mismatch", want, got);
      end
    end
  end

  task automatic send_transaction(logic func, logic [SEQ_W-1:0] s, logic [ADDR_W-1:0] a,
                                  logic [PORT_W-1:0] p, logic [RND_W-1:0] r);
    @(negedge clk_i);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i   <= 1'b0;
      func_i       <= 1'($urandom);
      seq_i        <= $urandom;
      src_addr_i   <= $urandom;
      src_port_i   <= PORT_W'($urandom);
      random_pct_i <= RND_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    seq_i        <= s;
    src_addr_i   <= a;
    src_port_i   <= p;
    random_pct_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_link(func, s, a, p, r);
  endtask

  task automatic send_packet(logic [RND_W-1:0] r);
    send_transaction(1'b0, $urandom, $urandom, PORT_W'($urandom), r);
  endtask

  task automatic send_tick();
    send_transaction(FUNC_TICK, $urandom, $urandom, PORT_W'($urandom), RND_W'($urandom));
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_RATE_LIMIT) model_rate = value;
    else model_cap = value[CAP_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_transaction(1'b0, '0, '0, '0, '0);
    send_transaction(1'b0, '1, '1, '1, RND_W'(99));
    send_tick();
    send_transaction(1'b0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'hC33C, RND_W'(42));
    wait_quiet();
  endtask

  task automatic test_single_slot_queue();
    write_register(CFG_RATE_LIMIT, '0);
    write_register(CFG_QUEUE_CAP, CFG_W'(1));
    send_packet(RND_W'(0));
    send_packet(RND_W'(127));
    send_tick();
    send_tick();
    wait_quiet();
  endtask

  task automatic test_capacity_bounds();
    // zero capacity with junk in the upper data bits
    write_register(CFG_QUEUE_CAP, {13'h1FFF, 7'd0});
    send_packet(RND_W'(99));
    send_packet(RND_W'(50));
    send_tick();
    wait_quiet();
    write_register(CFG_QUEUE_CAP, CFG_W'(127));
    send_packet(RND_W'(0));
    send_packet(RND_W'(1));
    send_packet(RND_W'(100));
    send_packet(RND_W'(3));
    send_tick();
    wait_quiet();
  endtask

  task automatic test_rate_extremes();
    write_register(CFG_RATE_LIMIT, CNT_MAX);
    repeat (3) send_packet(RND_W'($urandom_range(0, 99)));
    wait_quiet();
    write_register(CFG_RATE_LIMIT, CFG_W'(1));
    write_register(CFG_QUEUE_CAP, CFG_W'(QDEPTH));
    send_tick();
    send_packet(RND_W'(0));
    send_packet(RND_W'(0));
    wait_quiet();
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int hold_pct);
    logic [CFG_W-1:0] rate;
    logic [CFG_W-1:0] cap;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = hold_pct;
    case ($urandom_range(0, 5))
      0: rate = '0;
      1: rate = CNT_MAX;
      default: rate = CFG_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 5))
      0: cap = '0;
      1: cap = CFG_W'(127);
      2: cap = CFG_W'(QDEPTH);
      default: cap = CFG_W'($urandom_range(1, 12));
    endcase
    write_register(CFG_RATE_LIMIT, rate);
    write_register(CFG_QUEUE_CAP, cap);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) send_tick();
      else if ($urandom_range(0, 9) == 0) send_packet(RND_W'($urandom_range(100, 127)));
      else send_packet(RND_W'($urandom_range(0, 99)));
    end
    send_tick();
    wait_quiet();
  endtask

  task automatic test_full_queue_drain(int idle_pct, int hold_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = hold_pct;
    write_register(CFG_RATE_LIMIT, '0);
    write_register(CFG_QUEUE_CAP, CFG_W'(QDEPTH));
    send_tick();
    repeat (QDEPTH + 1) send_packet(RND_W'($urandom_range(100, 127)));
    send_tick();
    wait_quiet();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_single_slot_queue();
    test_capacity_bounds();
    test_rate_extremes();
    test_random_traffic(22, 0, 0);
    test_random_traffic(22, 49, 0);
    test_random_traffic(22, 0, 49);
    test_random_traffic(22, 10, 10);
    test_full_queue_drain(10, 10);

    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
